/* rtl/tekd_pkg.sv */
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types and constants of the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam int COORD_BITS = 16;
  localparam int ACC_W      = COORD_BITS + 4;
  localparam int POS_W      = (COORD_BITS + 1 > 17) ? COORD_BITS + 1 : 17;

  localparam logic [4:0] K_CHAR   = 5'd0;
  localparam logic [4:0] K_CTRL   = 5'd1;
  localparam logic [4:0] K_SPACE  = 5'd2;
  localparam logic [4:0] K_ENTER  = 5'd3;
  localparam logic [4:0] K_TAB    = 5'd4;
  localparam logic [4:0] K_BKSP   = 5'd5;
  localparam logic [4:0] K_UP     = 5'd6;
  localparam logic [4:0] K_HOME   = 5'd10;
  localparam logic [4:0] K_END    = 5'd11;
  localparam logic [4:0] K_INSERT = 5'd12;
  localparam logic [4:0] K_DELETE = 5'd13;
  localparam logic [4:0] K_PGUP   = 5'd14;
  localparam logic [4:0] K_PGDN   = 5'd15;
  localparam logic [4:0] K_FKEY   = 5'd16;
  localparam logic [4:0] K_NUMKEY = 5'd17;
  localparam logic [4:0] K_MOUSE  = 5'd18;

  localparam logic [7:0] B_ESC   = 8'h1B;
  localparam logic [7:0] B_CSI   = 8'h5B;
  localparam logic [7:0] B_SS3   = 8'h4F;
  localparam logic [7:0] B_TILDE = 8'h7E;
  localparam logic [7:0] B_LT    = 8'h3C;
  localparam logic [7:0] B_SEMI  = 8'h3B;
  localparam logic [7:0] B_PRESS = 8'h4D;
  localparam logic [7:0] B_REL   = 8'h6D;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } tekd_cmd_t;

  typedef struct packed {
    logic q_last;
    logic pend_v;
    logic slot_free;
  } tekd_stat_t;

endpackage

/* rtl/tekd_ctrl.sv */
// ----------------------------------------------------------------------------
// tekd_ctrl
// Sequencer: accepts a byte, steps the replay queue, flushes the last event.
// ----------------------------------------------------------------------------
module tekd_ctrl import tekd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tekd_stat_t stat,
  output tekd_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (stat.slot_free) begin
          cmd.step = 1'b1;
          if (stat.q_last) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/tekd_dp.sv */
// ----------------------------------------------------------------------------
// tekd_dp
// Byte queue, escape and mouse parser state, pending event and output word.
// ----------------------------------------------------------------------------
module tekd_dp import tekd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tekd_cmd_t          cmd,
  output tekd_stat_t         stat,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_kind,
  output logic signed [12:0] out_value,
  output logic signed [16:0] out_mouse_col,
  output logic signed [16:0] out_mouse_row,
  output logic [1:0]         out_mouse_button,
  output logic               out_last
);

  function automatic logic [COORD_BITS-1:0] acc_digit(input logic [COORD_BITS-1:0] a,
                                                      input logic [3:0] d);
    logic [ACC_W-1:0] v;
    v = (ACC_W'(a) << 3) + (ACC_W'(a) << 1) + ACC_W'(d);
    if (v > ACC_W'({COORD_BITS{1'b1}})) acc_digit = {COORD_BITS{1'b1}};
    else acc_digit = v[COORD_BITS-1:0];
  endfunction

  logic [7:0] q_r [4];
  logic [7:0] q_nxt [4];
  logic [2:0] qcnt_r, qcnt_nxt;

  logic [7:0] h1_r, h2_r, h3_r, h1_nxt, h2_nxt, h3_nxt;
  logic [2:0] hc_r, hc_nxt;
  logic [2:0] mph_r, mph_nxt;
  logic       mok_r, mok_nxt;
  logic [COORD_BITS-1:0] acc_r [3];
  logic [COORD_BITS-1:0] acc_nxt [3];
  logic [COORD_BITS-1:0] acc_d [3];
  logic signed [16:0] col_r, row_r, col_nxt, row_nxt;
  logic [1:0] btn_r, btn_nxt;

  logic               pend_v_r;
  logic [4:0]         pend_kind_r;
  logic signed [12:0] pend_val_r;
  logic signed [16:0] pend_col_r, pend_row_r;
  logic [1:0]         pend_btn_r;

  logic               out_valid_r;
  logic [4:0]         out_kind_r;
  logic signed [12:0] out_val_r;
  logic signed [16:0] out_col_r, out_row_r;
  logic [1:0]         out_btn_r;
  logic               out_last_r;

  logic [7:0]         b;
  logic               digit, res, unk, slot_free;
  logic [4:0]         r_kind;
  logic signed [12:0] r_val, ta, tb, nv;
  logic [POS_W-1:0]   pc_w, pr_w;

  assign b         = q_r[0];
  assign digit     = (b >= 8'h30) && (b <= 8'h39);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int k = 0; k < 3; k++) acc_d[k] = acc_digit(acc_r[k], b[3:0]);
  end

  assign ta   = $signed({5'b0, h2_r}) - 13'sd48;
  assign tb   = $signed({5'b0, h3_r}) - 13'sd48;
  assign nv   = (ta <<< 3) + (ta <<< 1) + tb;
  assign pc_w = POS_W'(acc_r[1]) - POS_W'(1);
  assign pr_w = POS_W'(acc_r[2]) - POS_W'(1);

  // one decode step on the queue head
  always_comb begin
    h1_nxt = h1_r; h2_nxt = h2_r; h3_nxt = h3_r;
    hc_nxt = hc_r; mph_nxt = mph_r; mok_nxt = mok_r;
    for (int k = 0; k < 3; k++) acc_nxt[k] = acc_r[k];
    col_nxt = col_r; row_nxt = row_r; btn_nxt = btn_r;
    res = 1'b0; unk = 1'b0; r_kind = K_CHAR; r_val = '0;
    if (mph_r != 3'd0) begin
      if (b == B_PRESS || b == B_REL) begin
        if (mok_r && (mph_r == 3'd6 || mph_r == 3'd7)) begin
          col_nxt = pc_w[16:0];
          row_nxt = pr_w[16:0];
          if (b == B_REL) btn_nxt = 2'd0;
          else if (acc_r[0][1:0] != 2'd3) btn_nxt = acc_r[0][1:0] + 2'd1;
        end
        mph_nxt = 3'd0;
        res     = 1'b1;
        r_kind  = K_MOUSE;
      end else begin
        case (mph_r)
          3'd1, 3'd3, 3'd5: begin
            if (digit) begin
              if (mph_r == 3'd1)      acc_nxt[0] = acc_d[0];
              else if (mph_r == 3'd3) acc_nxt[1] = acc_d[1];
              else                    acc_nxt[2] = acc_d[2];
              mph_nxt = mph_r + 3'd1;
            end else begin
              mok_nxt = 1'b0; mph_nxt = 3'd7;
            end
          end
          3'd2, 3'd4: begin
            if (digit) begin
              if (mph_r == 3'd2) acc_nxt[0] = acc_d[0];
              else               acc_nxt[1] = acc_d[1];
            end else if (b == B_SEMI) begin
              mph_nxt = mph_r + 3'd1;
            end else begin
              mok_nxt = 1'b0; mph_nxt = 3'd7;
            end
          end
          3'd6: begin
            if (digit) acc_nxt[2] = acc_d[2];
            else       mph_nxt = 3'd7;
          end
          default: ;
        endcase
      end
    end else if (hc_r == 3'd0) begin
      if (b == B_ESC) begin
        hc_nxt = 3'd1;
      end else if (b != 8'd0) begin
        res = 1'b1;
        if (b == 8'd3) begin
          r_kind = K_CTRL; r_val = 13'sd3;
        end else if (b == 8'd32) r_kind = K_SPACE;
        else if (b == 8'd13 || b == 8'd10) r_kind = K_ENTER;
        else if (b == 8'd9) r_kind = K_TAB;
        else if (b == 8'd127 || b == 8'd8) r_kind = K_BKSP;
        else if (b <= 8'd26) begin
          r_kind = K_CTRL; r_val = $signed({5'b0, b});
        end else begin
          r_kind = K_CHAR; r_val = $signed({5'b0, b});
        end
      end
    end else if (hc_r == 3'd1) begin
      if (b == B_CSI || b == B_SS3) begin
        h1_nxt = b; hc_nxt = 3'd2;
      end else unk = 1'b1;
    end else if (hc_r == 3'd2 && h1_r == B_CSI) begin
      hc_nxt = 3'd0;
      if (b == B_LT) begin
        mph_nxt = 3'd1; mok_nxt = 1'b1;
        for (int k = 0; k < 3; k++) acc_nxt[k] = '0;
      end else if (b >= 8'h41 && b <= 8'h44) begin
        res = 1'b1; r_kind = K_UP + b[4:0] - 5'd1;
      end else if (b == 8'h48) begin
        res = 1'b1; r_kind = K_HOME;
      end else if (b == 8'h46) begin
        res = 1'b1; r_kind = K_END;
      end else begin
        h2_nxt = b; hc_nxt = 3'd3;
      end
    end else if (hc_r == 3'd2) begin
      if (b >= 8'h50 && b <= 8'h53) begin
        hc_nxt = 3'd0; res = 1'b1; r_kind = K_FKEY;
        r_val = $signed({11'b0, b[1:0]}) + 13'sd1;
      end else unk = 1'b1;
    end else if (hc_r == 3'd3) begin
      if (b == B_TILDE) begin
        hc_nxt = 3'd0;
        res    = 1'b1;
        case (h2_r)
          8'h31:   r_kind = K_HOME;
          8'h32:   r_kind = K_INSERT;
          8'h33:   r_kind = K_DELETE;
          8'h34:   r_kind = K_END;
          8'h35:   r_kind = K_PGUP;
          8'h36:   r_kind = K_PGDN;
          default: res = 1'b0;
        endcase
      end else begin
        h3_nxt = b; hc_nxt = 3'd4;
      end
    end else begin
      if (b == B_TILDE) begin
        hc_nxt = 3'd0; res = 1'b1; r_kind = K_FKEY;
        if (nv >= 13'sd11 && nv <= 13'sd15)      r_val = nv - 13'sd10;
        else if (nv >= 13'sd17 && nv <= 13'sd21) r_val = nv - 13'sd11;
        else if (nv >= 13'sd23 && nv <= 13'sd24) r_val = nv - 13'sd12;
        else begin
          r_kind = K_NUMKEY; r_val = nv;
        end
      end else unk = 1'b1;
    end
    if (unk) hc_nxt = 3'd0;
  end

  // queue after the step, replayed bytes go in front
  always_comb begin
    q_nxt[0] = q_r[1]; q_nxt[1] = q_r[2]; q_nxt[2] = q_r[3]; q_nxt[3] = q_r[3];
    qcnt_nxt = qcnt_r - 3'd1;
    if (unk) begin
      case (hc_r)
        3'd1: begin
          q_nxt[0] = b; q_nxt[1] = q_r[1]; q_nxt[2] = q_r[2]; q_nxt[3] = q_r[3];
          qcnt_nxt = qcnt_r;
        end
        3'd2: begin
          q_nxt[0] = h1_r; q_nxt[1] = b; q_nxt[2] = q_r[1]; q_nxt[3] = q_r[2];
          qcnt_nxt = qcnt_r + 3'd1;
        end
        3'd3: begin
          q_nxt[0] = h1_r; q_nxt[1] = h2_r; q_nxt[2] = b; q_nxt[3] = q_r[1];
          qcnt_nxt = qcnt_r + 3'd2;
        end
        default: begin
          q_nxt[0] = h1_r; q_nxt[1] = h2_r; q_nxt[2] = h3_r; q_nxt[3] = b;
          qcnt_nxt = qcnt_r + 3'd3;
        end
      endcase
    end
  end

  assign stat.q_last    = !unk && (qcnt_r == 3'd1);
  assign stat.pend_v    = pend_v_r;
  assign stat.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r      <= '0;
      hc_r        <= '0;
      mph_r       <= '0;
      mok_r       <= 1'b0;
      for (int k = 0; k < 3; k++) acc_r[k] <= '0;
      col_r       <= -17'sd1;
      row_r       <= -17'sd1;
      btn_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        q_r[0] <= in_byte;
        qcnt_r <= 3'd1;
      end
      if (cmd.step) begin
        q_r    <= q_nxt;
        qcnt_r <= qcnt_nxt;
        h1_r   <= h1_nxt; h2_r <= h2_nxt; h3_r <= h3_nxt;
        hc_r   <= hc_nxt;
        mph_r  <= mph_nxt;
        mok_r  <= mok_nxt;
        acc_r  <= acc_nxt;
        col_r  <= col_nxt; row_r <= row_nxt; btn_r <= btn_nxt;
        if (res) begin
          pend_v_r    <= 1'b1;
          pend_kind_r <= r_kind;
          pend_val_r  <= r_val;
          pend_col_r  <= col_nxt;
          pend_row_r  <= row_nxt;
          pend_btn_r  <= btn_nxt;
        end
      end
      if ((cmd.step && res && pend_v_r) || cmd.flush) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= pend_kind_r;
        out_val_r   <= pend_val_r;
        out_col_r   <= pend_col_r;
        out_row_r   <= pend_row_r;
        out_btn_r   <= pend_btn_r;
        out_last_r  <= cmd.flush;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.flush) pend_v_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_val_r;
  assign out_mouse_col    = out_col_r;
  assign out_mouse_row    = out_row_r;
  assign out_mouse_button = out_btn_r;
  assign out_last         = out_last_r;

endmodule

/* rtl/terminal_escape_key_decoder.sv */
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Turns raw terminal bytes into key and mouse events.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   one terminal byte
//   out_     output     out_valid/out_stall one key or mouse event
//
// A byte is accepted, then decoded one step per queued byte, then its final
// event is handed over. An ordinary byte decodes once; an unknown prefix
// replays up to four held bytes and an escape among them can replay two more,
// so up to seven decode steps.
// The single decode step works through the replay queue before a new byte is taken.
// Reset is synchronous; position reads -1 and button none until a report.
// A stalled output holds the decoder in its current step.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder import tekd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_kind,
  output logic signed [12:0] out_value,
  output logic signed [16:0] out_mouse_col,
  output logic signed [16:0] out_mouse_row,
  output logic [1:0]         out_mouse_button,
  output logic               out_last
);

  tekd_cmd_t  cmd;
  tekd_stat_t stat;

  tekd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tekd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_mouse_col    (out_mouse_col),
    .out_mouse_row    (out_mouse_row),
    .out_mouse_button (out_mouse_button),
    .out_last         (out_last)
  );

endmodule

/* rtl/tekd_chk.sv */
// ----------------------------------------------------------------------------
// tekd_chk
// Port level checks of the terminal escape key decoder.
// ----------------------------------------------------------------------------
module tekd_chk import tekd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_kind,
  input logic signed [12:0] out_value,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_last))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= K_MOUSE)
    else $error("bad event kind");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind >= K_SPACE && out_kind <= K_PGDN) || out_kind == K_MOUSE)
      |-> out_value == 13'sd0)
    else $error("nonzero value on plain key");

endmodule

bind terminal_escape_key_decoder tekd_chk u_tekd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_value (out_value),
  .out_last  (out_last)
);

/* tb/sv/terminal_escape_key_decoder_checker.sv */
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_checker
// Watches the byte and event channels of the terminal escape key decoder,
// predicts the events that each accepted byte causes and compares them field
// by field with the events that the decoder hands over.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_checker import tekd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_kind,
  input  logic signed [12:0] out_value,
  input  logic signed [16:0] out_mouse_col,
  input  logic signed [16:0] out_mouse_row,
  input  logic [1:0]         out_mouse_button,
  input  logic               out_last,
  output int                 error_count,
  output int                 pending_events
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [12:0] value;
    logic signed [16:0] col;
    logic signed [16:0] row;
    logic [1:0]         button;
    logic               last;
  } key_event_t;

  key_event_t event_queue[$];
  key_event_t step_events[$];

  logic [7:0]  held[4];
  int          held_n;
  int          mphase;
  logic [31:0] macc[3];
  logic        mok;
  logic signed [16:0] cur_col, cur_row;
  logic [1:0]  cur_button;

  function automatic void emit(input logic [4:0] kind, input int value);
    key_event_t e;
    e.kind = kind;
    e.value = value[12:0];
    e.col = cur_col;
    e.row = cur_row;
    e.button = cur_button;
    e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  function automatic void decode_plain(input logic [7:0] b);
    if (b == 8'd0) begin
      return;
    end
    if (b == 8'd3) emit(K_CTRL, 3);
    else if (b == 8'd32) emit(K_SPACE, 0);
    else if (b == 8'd13 || b == 8'd10) emit(K_ENTER, 0);
    else if (b == 8'd9) emit(K_TAB, 0);
    else if (b == 8'd127 || b == 8'd8) emit(K_BKSP, 0);
    else if (b >= 8'd1 && b <= 8'd26) emit(K_CTRL, int'(b));
    else emit(K_CHAR, int'(b));
  endfunction

  function automatic void add_digit(input int k, input logic [7:0] b);
    longint v;
    longint lim;
    lim = (64'd1 << COORD_BITS) - 1;
    v = longint'(macc[k]) * 10 + (b - 8'h30);
    macc[k] = (v > lim) ? lim[31:0] : v[31:0];
  endfunction

  function automatic void decode_mouse(input logic [7:0] b);
    logic digit;
    logic [31:0] btn;
    digit = (b >= "0" && b <= "9");
    if (b == B_PRESS || b == B_REL) begin
      if (mok && (mphase == 6 || mphase == 7)) begin
        btn = macc[0];
        cur_col = 17'(longint'(macc[1]) - 1);
        cur_row = 17'(longint'(macc[2]) - 1);
        if (b == B_REL) cur_button = 2'd0;
        else if (btn[1:0] != 2'd3) cur_button = btn[1:0] + 2'd1;
      end
      mphase = 0;
      emit(K_MOUSE, 0);
      return;
    end
    case (mphase)
      1, 3, 5: begin
        if (digit) begin
          add_digit((mphase - 1) / 2, b);
          mphase++;
        end else begin
          mok = 1'b0;
          mphase = 7;
        end
      end
      2, 4: begin
        if (digit) add_digit((mphase - 2) / 2, b);
        else if (b == B_SEMI) mphase++;
        else begin
          mok = 1'b0;
          mphase = 7;
        end
      end
      6: begin
        if (digit) add_digit(2, b);
        else mphase = 7;
      end
      default: ;
    endcase
  endfunction

  // returns the number of bytes to replay, placed in replay
  function automatic int decode_byte(input logic [7:0] b, ref logic [7:0] replay[5]);
    int hc;
    int v;
    hc = held_n;
    if (mphase != 0) begin
      decode_mouse(b);
      return 0;
    end
    if (hc == 0) begin
      if (b == B_ESC) begin
        held[0] = b;
        held_n = 1;
      end else decode_plain(b);
      return 0;
    end
    if (hc == 1) begin
      if (b == B_CSI || b == B_SS3) begin
        held[1] = b;
        held_n = 2;
        return 0;
      end
    end else if (hc == 2 && held[1] == B_CSI) begin
      held_n = 0;
      if (b == B_LT) begin
        mphase = 1;
        mok = 1'b1;
        macc[0] = 0;
        macc[1] = 0;
        macc[2] = 0;
      end else if (b >= "A" && b <= "D") emit(5'(K_UP + b - "A"), 0);
      else if (b == "H") emit(K_HOME, 0);
      else if (b == "F") emit(K_END, 0);
      else begin
        held[2] = b;
        held_n = 3;
      end
      return 0;
    end else if (hc == 2) begin
      if (b >= "P" && b <= "S") begin
        held_n = 0;
        emit(K_FKEY, int'(b) - int'("P") + 1);
        return 0;
      end
    end else if (hc == 3) begin
      if (b == B_TILDE) begin
        held_n = 0;
        case (held[2])
          "1": emit(K_HOME, 0);
          "2": emit(K_INSERT, 0);
          "3": emit(K_DELETE, 0);
          "4": emit(K_END, 0);
          "5": emit(K_PGUP, 0);
          "6": emit(K_PGDN, 0);
          default: ;
        endcase
      end else begin
        held[3] = b;
        held_n = 4;
      end
      return 0;
    end else if (hc == 4 && b == B_TILDE) begin
      v = (int'(held[2]) - 48) * 10 + (int'(held[3]) - 48);
      held_n = 0;
      if (v >= 11 && v <= 15) emit(K_FKEY, v - 10);
      else if (v >= 17 && v <= 21) emit(K_FKEY, v - 11);
      else if (v >= 23 && v <= 24) emit(K_FKEY, v - 12);
      else emit(K_NUMKEY, v);
      return 0;
    end
    for (int i = 1; i < hc; i++) replay[i - 1] = held[i];
    replay[hc - 1] = b;
    held_n = 0;
    return hc;
  endfunction

  task automatic predict_events(input logic [7:0] b);
    logic [7:0] work[$];
    logic [7:0] replay[5];
    logic [7:0] cur;
    int k;
    key_event_t e;
    work.push_back(b);
    while (work.size() > 0) begin
      cur = work.pop_front();
      k = decode_byte(cur, replay);
      for (int i = k - 1; i >= 0; i--) work.push_front(replay[i]);
    end
    while (step_events.size() > 5) void'(step_events.pop_back());
    if (step_events.size() > 0) begin
      e = step_events.pop_back();
      e.last = 1'b1;
      step_events.push_back(e);
    end
    while (step_events.size() > 0) event_queue.push_back(step_events.pop_front());
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending_events = 0;
  end

  always @(posedge clk) begin
    key_event_t x;
    if (!rst_n) begin
      held_n = 0;
      mphase = 0;
      mok = 1'b0;
      macc[0] = 0;
      macc[1] = 0;
      macc[2] = 0;
      cur_col = -17'sd1;
      cur_row = -17'sd1;
      cur_button = 2'd0;
      event_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (event_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d", out_kind));
        end else begin
          x = event_queue.pop_front();
          if (out_kind !== x.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, x.kind));
          if (out_value !== x.value)
            report_mismatch($sformatf("value %0d, want %0d", out_value, x.value));
          if (out_mouse_col !== x.col)
            report_mismatch($sformatf("col %0d, want %0d", out_mouse_col, x.col));
          if (out_mouse_row !== x.row)
            report_mismatch($sformatf("row %0d, want %0d", out_mouse_row, x.row));
          if (out_mouse_button !== x.button)
            report_mismatch($sformatf("button %0d, want %0d", out_mouse_button, x.button));
          if (out_last !== x.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, x.last));
        end
      end
      if (in_valid && !in_stall) predict_events(in_byte);
    end
    pending_events = event_queue.size();
  end

endmodule

/* tb/sv/terminal_escape_key_decoder_test.sv */
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_test
// Feeds the decoder directed escape, key and mouse sequences, then random
// well-formed and broken sequences under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_test;
  import tekd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic               out_stall;
  logic [4:0]         out_kind;
  logic signed [12:0] out_value;
  logic signed [16:0] out_mouse_col;
  logic signed [16:0] out_mouse_row;
  logic [1:0]         out_mouse_button;
  logic               out_last;
  int                 error_count;
  int                 pending_events;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 quiet_cycles;
  logic [7:0]         byte_queue[$];

  terminal_escape_key_decoder dut (.*);

  terminal_escape_key_decoder_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) byte_queue.push_back(bytes[i]);
  endtask

  task automatic push_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
  endtask

  task automatic push_mouse(input int btn, input int col, input int row, input logic rel);
    push_bytes('{B_ESC, B_CSI, B_LT});
    push_number(btn);
    byte_queue.push_back(B_SEMI);
    push_number(col);
    byte_queue.push_back(B_SEMI);
    push_number(row);
    byte_queue.push_back(rel ? B_REL : B_PRESS);
  endtask

  task automatic push_random_sequence();
    int sel;
    sel = $urandom_range(11);
    case (sel)
      0: byte_queue.push_back(8'($urandom_range(255)));
      1: push_bytes('{B_ESC, B_CSI, 8'($urandom_range("A", "D"))});
      2: push_bytes('{B_ESC, B_SS3, 8'($urandom_range("P", "S"))});
      3: push_bytes('{B_ESC, B_CSI, 8'($urandom_range("0", "9")), B_TILDE});
      4: push_bytes('{B_ESC, B_CSI, 8'($urandom_range("0", "9")),
                      8'($urandom_range("0", "9")), B_TILDE});
      5, 6: push_mouse($urandom_range(99), $urandom_range(300), $urandom_range(300),
                       $urandom_range(1));
      7: push_mouse($urandom_range(99), $urandom_range(99999), $urandom, 1'b0);
      8: begin
        push_bytes('{B_ESC, B_CSI, B_LT, 8'($urandom_range(255))});
        byte_queue.push_back($urandom_range(1) ? B_PRESS : B_REL);
      end
      9: push_bytes('{B_ESC, 8'($urandom_range(255)), 8'($urandom_range(255))});
      10: push_bytes('{B_ESC, B_CSI, 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255))});
      default: push_bytes('{B_ESC, B_SS3, 8'($urandom_range(255))});
    endcase
  endtask

  task automatic send_all();
    while (byte_queue.size() > 0) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid <= 1'b1;
        in_byte <= byte_queue.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_byte = 8'd0;
    quiet_cycles = 0;
    send_idle_pct = 8;
    recv_stall_pct = 60;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    push_bytes('{8'd0, 8'd3, 8'd255, 8'd32, 8'd13, 8'd10, 8'd9, 8'd127, 8'd8, 8'd26, 8'd128});
    push_bytes('{B_ESC, B_CSI, "A", B_ESC, B_CSI, "H", B_ESC, B_CSI, "F"});
    push_bytes('{B_ESC, B_SS3, "S", B_ESC, B_CSI, "7", B_TILDE});
    push_bytes('{B_ESC, B_CSI, "2", "4", B_TILDE, B_ESC, B_CSI, "9", "9", B_TILDE});
    push_bytes('{B_ESC, "x", B_ESC, B_CSI, "1", "2", "z", B_ESC, B_SS3, "Z"});
    push_mouse(0, 1, 1, 1'b0);
    push_mouse(35, 99999, 70000, 1'b0);
    push_bytes('{B_ESC, B_CSI, B_LT, "-", "1", B_REL});
    send_all();
    for (int i = 0; i < 10; i++) push_random_sequence();
    send_all();
    send_idle_pct = 60;
    recv_stall_pct = 8;
    for (int i = 0; i < 6; i++) push_random_sequence();
    send_all();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 6; i++) push_random_sequence();
    send_all();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_events > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
